>>> sv/rrcc_pkg.sv
// ----------------------------------------------------------------------------
// rrcc_pkg
// Shared types, codes and constants of the RGBC ratio colour classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rrcc_pkg;

	localparam int unsigned ChanW    = 16;  // raw count width
	localparam int unsigned CorrW    = 18;  // signed lit - dark - offset
	localparam int unsigned RemW     = 23;  // 100 * 65535 fits in 23 bits
	localparam int unsigned QuoW     = 8;   // saturated percentage
	localparam int unsigned CodeW    = 4;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned PctScale = 100;

	// classification thresholds, in percent of corrected clear
	localparam logic [QuoW-1:0] RedRedThr    = QuoW'(65);
	localparam logic [QuoW-1:0] GreenRedThr  = QuoW'(11);
	localparam logic [QuoW-1:0] RedYelThr    = QuoW'(52);
	localparam logic [QuoW-1:0] GreenYelThr  = QuoW'(29);
	localparam logic [QuoW-1:0] BlueYelThr   = QuoW'(21);
	localparam logic [QuoW-1:0] RedLbThr     = QuoW'(35);
	localparam logic [QuoW-1:0] RedWhiteThr  = QuoW'(45);
	localparam logic [QuoW-1:0] RedLowThr    = QuoW'(15);
	localparam logic [QuoW-1:0] BlueBlueThr  = QuoW'(30);
	localparam logic [QuoW-1:0] ShareMax     = '1;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CLEAR_OFFSET = 3'd0,
		CFG_RED_OFFSET   = 3'd1,
		CFG_GREEN_OFFSET = 3'd2,
		CFG_BLUE_OFFSET  = 3'd3,
		CFG_BLACK_LIMIT  = 3'd4
	} rrcc_cfg_idx_t;

	typedef enum logic [CodeW-1:0] {
		COL_UNKNOWN    = 4'd0,
		COL_RED        = 4'd1,
		COL_GREEN      = 4'd2,
		COL_BLUE       = 4'd3,
		COL_YELLOW     = 4'd4,
		COL_PINK       = 4'd5,
		COL_ORANGE     = 4'd6,
		COL_LIGHT_BLUE = 4'd7,
		COL_WHITE      = 4'd8,
		COL_BLACK      = 4'd9
	} rrcc_color_t;

	typedef struct packed {
		logic [ChanW-1:0] clear_offset;
		logic [ChanW-1:0] red_offset;
		logic [ChanW-1:0] green_offset;
		logic [ChanW-1:0] blue_offset;
		logic [ChanW-1:0] black_limit;
	} rrcc_cfg_t;

	typedef struct packed {
		logic [ChanW-1:0] lit_clear;
		logic [ChanW-1:0] lit_red;
		logic [ChanW-1:0] lit_green;
		logic [ChanW-1:0] lit_blue;
		logic [ChanW-1:0] dark_clear;
		logic [ChanW-1:0] dark_red;
		logic [ChanW-1:0] dark_green;
		logic [ChanW-1:0] dark_blue;
	} rrcc_sample_t;

	// corrected channels, two's complement
	typedef struct packed {
		logic             black;
		logic [CorrW-1:0] clear;
		logic [CorrW-1:0] red;
		logic [CorrW-1:0] green;
		logic [CorrW-1:0] blue;
	} rrcc_corr_t;

	typedef struct packed {
		logic            sat;
		logic [RemW-1:0] rem;
		logic [QuoW-1:0] quo;
	} rrcc_chan_t;

	typedef struct packed {
		logic             black;
		logic             fault;
		logic [ChanW-1:0] den;
		rrcc_chan_t       red;
		rrcc_chan_t       green;
		rrcc_chan_t       blue;
	} rrcc_div_t;

	typedef struct packed {
		rrcc_color_t     code;
		logic [QuoW-1:0] red_share;
		logic [QuoW-1:0] green_share;
		logic [QuoW-1:0] blue_share;
		logic            clear_fault;
	} rrcc_result_t;

	function automatic rrcc_color_t classify(input logic [QuoW-1:0] r,
			input logic [QuoW-1:0] g, input logic [QuoW-1:0] b);
		rrcc_color_t code;
		if (r >= RedRedThr) begin
			code = (g < GreenRedThr) ? COL_RED : COL_ORANGE;
		end else if (r >= RedYelThr) begin
			code = (g >= GreenYelThr && b < BlueYelThr) ? COL_YELLOW : COL_PINK;
		end else if (r >= RedLbThr) begin
			code = (r >= RedWhiteThr) ? COL_WHITE : COL_LIGHT_BLUE;
		end else if (r >= RedLowThr) begin
			code = (b >= BlueBlueThr) ? COL_BLUE : COL_GREEN;
		end else begin
			code = COL_UNKNOWN;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

>>> sv/rrcc_correct.sv
// ----------------------------------------------------------------------------
// rrcc_correct
// First stage: black test on the raw lit clear count and dark / crosstalk
// correction of all four channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcc_correct (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rrcc_pkg::rrcc_cfg_t cfg,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire rrcc_pkg::rrcc_sample_t in_data,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      rrcc_pkg::rrcc_corr_t out_data
);

	logic                 valid_s1;
	rrcc_pkg::rrcc_corr_t data_s1;
	rrcc_pkg::rrcc_corr_t corr;

	function automatic logic [rrcc_pkg::CorrW-1:0] fix(
			input logic [rrcc_pkg::ChanW-1:0] lit,
			input logic [rrcc_pkg::ChanW-1:0] dark,
			input logic [rrcc_pkg::ChanW-1:0] off);
		return rrcc_pkg::CorrW'(lit) - rrcc_pkg::CorrW'(dark) - rrcc_pkg::CorrW'(off);
	endfunction

	always_comb begin
		corr.black = (in_data.lit_clear <= cfg.black_limit);
		corr.clear = fix(in_data.lit_clear, in_data.dark_clear, cfg.clear_offset);
		corr.red   = fix(in_data.lit_red,   in_data.dark_red,   cfg.red_offset);
		corr.green = fix(in_data.lit_green, in_data.dark_green, cfg.green_offset);
		corr.blue  = fix(in_data.lit_blue,  in_data.dark_blue,  cfg.blue_offset);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= corr;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

>>> sv/rrcc_scale.sv
// ----------------------------------------------------------------------------
// rrcc_scale
// Second stage: clear fault test, 100x numerators and the saturation test
// that keeps the divider quotient within eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcc_scale (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire rrcc_pkg::rrcc_corr_t in_data,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      rrcc_pkg::rrcc_div_t  out_data
);

	logic                valid_s2;
	rrcc_pkg::rrcc_div_t data_s2;
	rrcc_pkg::rrcc_div_t nxt;

	function automatic rrcc_pkg::rrcc_chan_t numer(
			input logic [rrcc_pkg::CorrW-1:0] part,
			input logic [rrcc_pkg::ChanW-1:0] den);
		rrcc_pkg::rrcc_chan_t ch;
		logic                 pos;
		logic [rrcc_pkg::RemW-1:0] n;
		// negative or zero part gives a zero share
		pos = !part[rrcc_pkg::CorrW-1] && (part != '0);
		n   = pos ? rrcc_pkg::RemW'(part[rrcc_pkg::ChanW-1:0]) *
				rrcc_pkg::RemW'(rrcc_pkg::PctScale) : '0;
		ch.rem = n;
		ch.quo = '0;
		ch.sat = ({1'b0, n} >= {den, rrcc_pkg::QuoW'(0)});
		return ch;
	endfunction

	always_comb begin
		nxt.black = in_data.black;
		nxt.fault = in_data.clear[rrcc_pkg::CorrW-1] || (in_data.clear == '0);
		nxt.den   = in_data.clear[rrcc_pkg::ChanW-1:0];
		nxt.red   = numer(in_data.red,   nxt.den);
		nxt.green = numer(in_data.green, nxt.den);
		nxt.blue  = numer(in_data.blue,  nxt.den);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

>>> sv/rrcc_div_step.sv
// ----------------------------------------------------------------------------
// rrcc_div_step
// One restoring division stage: settles quotient bit BIT of all three
// channel shares against the corrected clear value.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcc_div_step #(
	parameter int unsigned BIT = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire rrcc_pkg::rrcc_div_t in_data,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      rrcc_pkg::rrcc_div_t out_data
);

	logic                valid_q;
	rrcc_pkg::rrcc_div_t data_q;
	rrcc_pkg::rrcc_div_t nxt;
	logic [rrcc_pkg::RemW-1:0] dsh;

	function automatic rrcc_pkg::rrcc_chan_t step(input rrcc_pkg::rrcc_chan_t ch,
			input logic [rrcc_pkg::RemW-1:0] d);
		rrcc_pkg::rrcc_chan_t o;
		o = ch;
		if (ch.rem >= d) begin
			o.rem      = ch.rem - d;
			o.quo[BIT] = 1'b1;
		end
		return o;
	endfunction

	assign dsh = rrcc_pkg::RemW'(in_data.den) << BIT;

	always_comb begin
		nxt       = in_data;
		nxt.red   = step(in_data.red,   dsh);
		nxt.green = step(in_data.green, dsh);
		nxt.blue  = step(in_data.blue,  dsh);
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

>>> sv/rrcc_classify.sv
// ----------------------------------------------------------------------------
// rrcc_classify
// Last stage: share saturation, black / fault overrides, threshold tree.
// Its register is the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcc_classify (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire rrcc_pkg::rrcc_div_t    in_data,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      rrcc_pkg::rrcc_result_t out_data
);

	logic                   valid_q;
	rrcc_pkg::rrcc_result_t data_q;
	rrcc_pkg::rrcc_result_t nxt;
	logic [rrcc_pkg::QuoW-1:0] rs, gs, bs;

	assign rs = in_data.red.sat   ? rrcc_pkg::ShareMax : in_data.red.quo;
	assign gs = in_data.green.sat ? rrcc_pkg::ShareMax : in_data.green.quo;
	assign bs = in_data.blue.sat  ? rrcc_pkg::ShareMax : in_data.blue.quo;

	always_comb begin
		nxt = '0;
		if (in_data.black) begin
			nxt.code = rrcc_pkg::COL_BLACK;
		end else if (in_data.fault) begin
			nxt.code        = rrcc_pkg::COL_UNKNOWN;
			nxt.clear_fault = 1'b1;
		end else begin
			nxt.code        = rrcc_pkg::classify(rs, gs, bs);
			nxt.red_share   = rs;
			nxt.green_share = gs;
			nxt.blue_share  = bs;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

>>> sv/rgbc_ratio_color_classifier_top.sv
// Path: each accepted input word passes the registered stages in order
// (correction, scaling, eight restoring divider stages, classification).
// Throughput: one word per cycle unless the output stalls; each stage holds one
// word and takes another when empty or its word moves on; bubbles close up.
// Reset: arst_n clears all stage valid bits and the offset / black limit
// registers to zero.
// ----------------------------------------------------------------------------
// rgbc_ratio_color_classifier_top
// RGBC ratio colour classifier: dark and crosstalk correction, pipelined
// percentage division and fixed threshold tree.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_ratio_color_classifier_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration
	input  wire logic         cfg_wen,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	// input words
	input  wire logic         s_axis_tvalid,
	output      logic         s_axis_tready,
	// lit_clear, lit_red, lit_green, lit_blue,
	// dark_clear, dark_red, dark_green, dark_blue (16 bits each)
	input  wire logic [127:0] s_axis_tdata,
	// output words
	output      logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// color_code[3:0], red_share[11:4], green_share[19:12],
	// blue_share[27:20], clear_fault[28], zero pad [31:29]
	output      logic [31:0]  m_axis_tdata
);

	localparam int unsigned NumSteps = rrcc_pkg::QuoW;

	rrcc_pkg::rrcc_cfg_t    cfg_q;
	rrcc_pkg::rrcc_sample_t sample;
	rrcc_pkg::rrcc_corr_t   corr;
	rrcc_pkg::rrcc_result_t res;
	logic                   corr_valid, corr_ready;

	rrcc_pkg::rrcc_div_t div_data  [0:NumSteps];
	logic                div_valid [0:NumSteps];
	logic                div_ready [0:NumSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				rrcc_pkg::CFG_CLEAR_OFFSET: cfg_q.clear_offset <= cfg_data;
				rrcc_pkg::CFG_RED_OFFSET:   cfg_q.red_offset   <= cfg_data;
				rrcc_pkg::CFG_GREEN_OFFSET: cfg_q.green_offset <= cfg_data;
				rrcc_pkg::CFG_BLUE_OFFSET:  cfg_q.blue_offset  <= cfg_data;
				rrcc_pkg::CFG_BLACK_LIMIT:  cfg_q.black_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		sample.lit_clear  = s_axis_tdata[15:0];
		sample.lit_red    = s_axis_tdata[31:16];
		sample.lit_green  = s_axis_tdata[47:32];
		sample.lit_blue   = s_axis_tdata[63:48];
		sample.dark_clear = s_axis_tdata[79:64];
		sample.dark_red   = s_axis_tdata[95:80];
		sample.dark_green = s_axis_tdata[111:96];
		sample.dark_blue  = s_axis_tdata[127:112];
	end

	rrcc_correct u_correct (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (sample),
		.out_valid (corr_valid),
		.out_ready (corr_ready),
		.out_data  (corr)
	);

	rrcc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (corr_valid),
		.in_ready  (corr_ready),
		.in_data   (corr),
		.out_valid (div_valid[0]),
		.out_ready (div_ready[0]),
		.out_data  (div_data[0])
	);

	// quotient bits from the top down
	for (genvar i = 0; i < NumSteps; i++) begin : g_div
		rrcc_div_step #(
			.BIT (NumSteps - 1 - i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[i]),
			.in_ready  (div_ready[i]),
			.in_data   (div_data[i]),
			.out_valid (div_valid[i+1]),
			.out_ready (div_ready[i+1]),
			.out_data  (div_data[i+1])
		);
	end

	rrcc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid[NumSteps]),
		.in_ready  (div_ready[NumSteps]),
		.in_data   (div_data[NumSteps]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {3'b000, res.clear_fault, res.blue_share, res.green_share,
		res.red_share, res.code};

endmodule

`default_nettype wire
